// ===== rtl/ppi3_pkg.sv =====
// Shared types, constants and the Q15 coefficient tables of the x3 polyphase interpolator.
// Used by every module in this folder; depends on nothing.
package ppi3_pkg;

  localparam int TAPS    = 32;
  localparam int PHASES  = 3;
  localparam int HIST    = TAPS - 1;
  localparam int SMP_W   = 16;
  localparam int ACC_W   = 34;

  typedef logic signed [SMP_W-1:0] sample_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  // Polyphase branch codes
  localparam logic [1:0] PH_A = 2'd0;
  localparam logic [1:0] PH_B = 2'd1;
  localparam logic [1:0] PH_C = 2'd2;

  // Configuration register indexes
  localparam logic CFG_SATURATE = 1'b0;
  localparam logic CFG_STEREO   = 1'b1;

  // Control that travels with one accumulated sum into the output stage
  typedef struct packed {
    logic       vld;
    logic       last;
    logic [1:0] ph;
  } res_ctl_t;

  // Coefficients, oldest tap first, one row per branch
  localparam sample_t COEF [PHASES][TAPS] = '{
    '{ 16'sd53, -16'sd29, 16'sd51, -16'sd81, 16'sd122, -16'sd172, 16'sd229, -16'sd288,
       16'sd340, -16'sd367, 16'sd343, -16'sd224, -16'sd64, 16'sd651, -16'sd1768, 16'sd1042,
       -16'sd1770, 16'sd2040, -16'sd2144, 16'sd2003, -16'sd1533, 16'sd663, 16'sd660,
       -16'sd2424, 16'sd4494, -16'sd6472, 16'sd7424, -16'sd5316, -16'sd3829, 16'sd23775,
       16'sd12709, 16'sd659 },
    '{ 16'sd19, -16'sd34, 16'sd53, -16'sd70, 16'sd86, -16'sd96, 16'sd94, -16'sd70,
       16'sd12, 16'sd94, -16'sd268, 16'sd531, -16'sd905, 16'sd1393, -16'sd1875, 16'sd741,
       -16'sd1279, 16'sd956, -16'sd467, -16'sd243, 16'sd1165, -16'sd2249, 16'sd3391,
       -16'sd4394, 16'sd4936, -16'sd4502, 16'sd2317, 16'sd2632, -16'sd10896, 16'sd17759,
       16'sd19294, 16'sd2649 },
    '{ 16'sd2, -16'sd35, 16'sd13, -16'sd5, -16'sd12, 16'sd43, -16'sd94, 16'sd168,
       -16'sd271, 16'sd405, -16'sd568, 16'sd749, -16'sd919, 16'sd1003, -16'sd789, -16'sd563,
       16'sd85, -16'sd799, 16'sd1443, -16'sd2110, 16'sd2722, -16'sd3166, 16'sd3287,
       -16'sd2890, 16'sd1741, 16'sd397, -16'sd3674, 16'sd7822, -16'sd11148, 16'sd7258,
       16'sd23879, 16'sd6696 }
  };

  // Coefficient of one tap for the branch now being worked on
  function automatic sample_t coef_sel(logic [1:0] ph, int tap);
    sample_t c;
    case (ph)
      PH_A:    c = COEF[0][tap];
      PH_B:    c = COEF[1][tap];
      PH_C:    c = COEF[2][tap];
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/ppi3_cell.sv =====
// One tap cell of the transposed FIR chain: three partial sums, one per branch, one MAC.
// Depends on ppi3_pkg.
module ppi3_cell import ppi3_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic [1:0] ph,
  input  sample_t    x,
  input  sample_t    coef,
  input  acc_t       sum_in,
  output acc_t       sum_out
);

  acc_t                     ps_r [PHASES];
  acc_t                     ps_nxt;
  logic signed [2*SMP_W-1:0] prod;

  // Partial sum of the active branch goes to the next cell
  always_comb begin
    case (ph)
      PH_A:    sum_out = ps_r[0];
      PH_B:    sum_out = ps_r[1];
      default: sum_out = ps_r[2];
    endcase
  end

  // Multiply-accumulate onto the neighbor's old partial sum
  assign prod   = coef * x;
  assign ps_nxt = sum_in + ACC_W'(prod);

  // Zero partial sums match an all-zero history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PHASES; i++) ps_r[i] <= '0;
    end else if (en) begin
      case (ph)
        PH_A:    ps_r[0] <= ps_nxt;
        PH_B:    ps_r[1] <= ps_nxt;
        default: ps_r[2] <= ps_nxt;
      endcase
    end
  end

endmodule

// ===== rtl/ppi3_out.sv =====
// Output stage: rounds and clips or wraps each sum, repeats it as a right copy in stereo mode.
// Depends on ppi3_pkg.
module ppi3_out import ppi3_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  acc_t       acc,
  input  res_ctl_t   ctl,
  input  logic       sat_en,
  input  logic       stereo,
  output logic       take,
  output logic       out_valid,
  input  logic       out_stall,
  output sample_t    out_sample_out,
  output logic [1:0] out_phase,
  output logic       out_channel,
  output logic       out_last
);

  logic                  vld_r;
  sample_t               smp_r;
  logic [1:0]            ph_r;
  logic                  ch_r;
  logic                  last_r;
  logic                  plast_r;
  logic                  xfer;
  logic                  dup;
  logic signed [ACC_W:0] rnd;
  logic signed [ACC_W-15:0] rs;
  sample_t               fin;

  // Round half up, floor shift by 15, then clip or wrap
  assign rnd = (ACC_W+1)'(acc) + (ACC_W+1)'(16384);
  assign rs  = rnd[ACC_W:15];
  always_comb begin
    if (sat_en && (rs > (ACC_W-14)'(32767)))
      fin = 16'sh7fff;
    else if (sat_en && (rs < -(ACC_W-14)'(32768)))
      fin = 16'sh8000;
    else
      fin = rs[SMP_W-1:0];
  end

  // Left copy held in stereo mode turns into the right copy after its transfer
  assign xfer = vld_r && !out_stall;
  assign dup  = stereo && !ch_r;
  assign take = ctl.vld && (!vld_r || (xfer && !dup));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (take) begin
      vld_r   <= 1'b1;
      smp_r   <= fin;
      ph_r    <= ctl.ph;
      ch_r    <= 1'b0;
      last_r  <= ctl.last && !stereo;
      plast_r <= ctl.last;
    end else if (xfer && dup) begin
      ch_r   <= 1'b1;
      last_r <= plast_r;
    end else if (xfer) begin
      vld_r <= 1'b0;
    end
  end

  assign out_valid      = vld_r;
  assign out_sample_out = smp_r;
  assign out_phase      = ph_r;
  assign out_channel    = ch_r;
  assign out_last       = last_r;

endmodule

// ===== rtl/polyphase_interpolator_x3.sv =====
// Each result is registered in the sum register and then in the output register.
// Each input gives 3 results (mono) or 6 (stereo); the output port passes one per cycle unless
// stalled, and the cell chain does one branch (one MAC per cell) each cycle while not held back.
// Reset (rst_n low, synchronous): partial sums cleared (all-zero history), saturation on,
// stereo off, no result pending. Depends on ppi3_pkg, ppi3_cell, ppi3_out.
module polyphase_interpolator_x3 import ppi3_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  sample_t    in_sample_in,
  output logic       out_valid,
  input  logic       out_stall,
  output sample_t    out_sample_out,
  output logic [1:0] out_phase,
  output logic       out_channel,
  output logic       out_last,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic       cfg_wdata
);

  sample_t    x_r;
  logic [1:0] ph_r;
  logic       busy_r;
  logic       sat_r;
  logic       stereo_r;
  acc_t       a_acc_r;
  res_ctl_t   a_ctl_r;
  logic       a_take;
  logic       adv;
  logic       last_ph;
  logic       in_xfer;
  acc_t       chain [HIST];
  acc_t       acc_fin;
  logic signed [2*SMP_W-1:0] prod_fin;

  // Engine steps one branch per cycle while the sum register can move on
  assign adv      = busy_r && (!a_ctl_r.vld || a_take);
  assign last_ph  = (ph_r == PH_C);
  assign in_stall = busy_r && !(adv && last_ph);
  assign in_xfer  = in_valid && !in_stall;

  // Chain of tap cells, oldest tap at cell 0
  for (genvar j = 0; j < HIST; j++) begin : g_cell
    ppi3_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .ph      (ph_r),
      .x       (x_r),
      .coef    (coef_sel(ph_r, j)),
      .sum_in  ((j == 0) ? acc_t'(0) : chain[(j == 0) ? 0 : j-1]),
      .sum_out (chain[j])
    );
  end

  // Newest tap closes the sum for the active branch
  assign prod_fin = coef_sel(ph_r, TAPS-1) * x_r;
  assign acc_fin  = chain[HIST-1] + ACC_W'(prod_fin);

  // Sequencer, config registers and the sum register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      ph_r     <= PH_A;
      sat_r    <= 1'b1;
      stereo_r <= 1'b0;
      a_ctl_r  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SATURATE: sat_r    <= cfg_wdata;
          CFG_STEREO:   stereo_r <= cfg_wdata;
          default:      ;
        endcase
      end
      if (in_xfer) begin
        x_r    <= in_sample_in;
        busy_r <= 1'b1;
        ph_r   <= PH_A;
      end else if (adv && last_ph) begin
        busy_r <= 1'b0;
        ph_r   <= PH_A;
      end else if (adv) begin
        ph_r <= ph_r + 2'd1;
      end
      if (adv) begin
        a_acc_r      <= acc_fin;
        a_ctl_r.vld  <= 1'b1;
        a_ctl_r.last <= last_ph;
        a_ctl_r.ph   <= ph_r;
      end else if (a_take) begin
        a_ctl_r.vld <= 1'b0;
      end
    end
  end

  ppi3_out u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .acc            (a_acc_r),
    .ctl            (a_ctl_r),
    .sat_en         (sat_r),
    .stereo         (stereo_r),
    .take           (a_take),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out),
    .out_phase      (out_phase),
    .out_channel    (out_channel),
    .out_last       (out_last)
  );

endmodule
